FILE: design/fse_pkg.sv
// ----------------------------------------------------------------------------
// fse_pkg: shared types and constants of the stencil Euler update unit
// Value format, register codes and the datapath command/status bundles.
// ----------------------------------------------------------------------------
package fse_pkg;

  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned DEF_MAX_COLS = 1024;
  localparam int unsigned DEF_MAX_ROWS = 4096;

  localparam int unsigned ROW_W      = 12;  // stored row position
  localparam int unsigned COL_W      = 10;  // stored column position
  localparam int unsigned ROW_CALC_W = 17;  // holds MAX_ROWS up to 65536
  localparam int unsigned COL_CALC_W = 13;  // holds MAX_COLS up to 4096
  localparam int unsigned MAG_W      = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIFF_W     = VALUE_WIDTH + 3;
  localparam int unsigned PROD_W     = DIFF_W + 33;
  localparam int unsigned STEP_W     = VALUE_WIDTH + 33;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd5;

  typedef struct packed {
    logic [31:0]      coef_x;
    logic [31:0]      coef_y;
    logic [31:0]      time_step;
    logic [12:0]      grid_rows;
    logic [10:0]      grid_cols;
    logic [MAG_W-1:0] converge_limit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic window;
    logic mul;
    logic sum;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic interior;
    logic out_free;
  } status_t;

endpackage

FILE: design/fse_if.sv
// ----------------------------------------------------------------------------
// fse channel interfaces
// Node input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface fse_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] u_prev;
  logic signed [31:0] source_term;
  logic               first_of_grid;
  modport source (output valid, u_prev, source_term, first_of_grid, input ready);
  modport sink (input valid, u_prev, source_term, first_of_grid, output ready);
endinterface

interface fse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] u_new;
  logic signed [31:0] node_residual;
  logic [11:0]        row_index;
  logic [9:0]         col_index;
  logic [30:0]        max_abs_residual;
  logic               last_of_sweep;
  logic               converged;
  modport source (output valid, u_new, node_residual, row_index, col_index,
                  max_abs_residual, last_of_sweep, converged, input ready);
  modport sink (input valid, u_new, node_residual, row_index, col_index,
                max_abs_residual, last_of_sweep, converged, output ready);
endinterface

interface fse_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/fse_cfg.sv
// ----------------------------------------------------------------------------
// fse_cfg: configuration register file
// Six registers written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module fse_cfg
  import fse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_x         <= 32'd67108864;
      cfg_q.coef_y         <= 32'd67108864;
      cfg_q.time_step      <= 32'd4096;
      cfg_q.grid_rows      <= 13'd513;
      cfg_q.grid_cols      <= 11'd513;
      cfg_q.converge_limit <= 31'd17;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        REG_COEF_X:    cfg_q.coef_x         <= wr_data_i;
        REG_COEF_Y:    cfg_q.coef_y         <= wr_data_i;
        REG_TIME_STEP: cfg_q.time_step      <= wr_data_i;
        REG_ROWS:      cfg_q.grid_rows      <= wr_data_i[12:0];
        REG_COLS:      cfg_q.grid_cols      <= wr_data_i[10:0];
        REG_LIMIT:     cfg_q.converge_limit <= wr_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: design/fse_ctrl.sv
// ----------------------------------------------------------------------------
// fse_ctrl: sequencing controller
// Steps a node through read, window and, if interior, mul, sum, step, finish.
// ----------------------------------------------------------------------------
module fse_ctrl
  import fse_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_WINDOW, S_MUL, S_SUM, S_STEP, S_FINISH
  } state_e;

  state_e state_q;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_WINDOW;
        S_WINDOW: state_q <= status_i.interior ? S_MUL : S_IDLE;
        S_MUL:    state_q <= S_SUM;
        S_SUM:    state_q <= S_STEP;
        S_STEP:   state_q <= S_FINISH;
        S_FINISH: if (status_i.out_free) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  // commands
  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.accept  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.window  = (state_q == S_WINDOW);
  assign cmd_o.mul     = (state_q == S_MUL);
  assign cmd_o.sum     = (state_q == S_SUM);
  assign cmd_o.step    = (state_q == S_STEP);
  assign cmd_o.finish  = (state_q == S_FINISH) && status_i.out_free;

endmodule

FILE: design/fse_dpath.sv
// ----------------------------------------------------------------------------
// fse_dpath: stencil datapath
// Row stores, window registers, multipliers, saturation and output register.
// ----------------------------------------------------------------------------
module fse_dpath
  import fse_pkg::*;
#(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic signed [31:0] u_prev_i,
  input  logic signed [31:0] source_i,
  input  logic               first_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] u_new_o,
  output logic signed [31:0] node_residual_o,
  output logic [ROW_W-1:0]   row_index_o,
  output logic [COL_W-1:0]   col_index_o,
  output logic [MAG_W-1:0]   max_abs_residual_o,
  output logic               last_of_sweep_o,
  output logic               converged_o
);

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  // row stores
  logic [31:0] upper_mem [MAX_COLS];
  logic [31:0] middle_mem [MAX_COLS];
  logic [31:0] source_mem [MAX_COLS];

  logic [ROW_W-1:0] row_q, r_q;
  logic [COL_W-1:0] col_q, c_q;
  logic [MAG_W-1:0] max_q;
  logic [AW-1:0]    idx_q;
  logic signed [31:0] u_in_q, s_in_q, up_rd_q, mid_rd_q, src_rd_q;
  logic signed [31:0] west_q, ctr_q, north_q, south_q, wsrc_q;
  logic signed [DIFF_W-1:0] dr_q, dc_q;
  logic signed [31:0] src_s_q, ctr_s_q, res_q;
  logic last_q, wrap_q;
  logic signed [PROD_W-1:0] px_q, py_q;
  logic signed [STEP_W-1:0] pt_q;

  // clamped grid size
  logic [ROW_CALC_W-1:0] rows_c;
  logic [COL_CALC_W-1:0] cols_c;
  always_comb begin
    rows_c = ROW_CALC_W'(cfg_i.grid_rows);
    if (rows_c < ROW_CALC_W'(3)) rows_c = ROW_CALC_W'(3);
    else if (rows_c > ROW_CALC_W'(MAX_ROWS)) rows_c = ROW_CALC_W'(MAX_ROWS);
    cols_c = COL_CALC_W'(cfg_i.grid_cols);
    if (cols_c < COL_CALC_W'(3)) cols_c = COL_CALC_W'(3);
    else if (cols_c > COL_CALC_W'(MAX_COLS)) cols_c = COL_CALC_W'(MAX_COLS);
  end

  // position of the arriving node and its store address
  logic [ROW_W-1:0]      r_eff;
  logic [COL_W-1:0]      c_eff;
  logic [COL_CALC_W-1:0] idx_w;
  logic [AW-1:0]         idx;
  assign r_eff = first_i ? '0 : row_q;
  assign c_eff = first_i ? '0 : col_q;
  assign idx_w = (COL_CALC_W'(c_eff) < COL_CALC_W'(MAX_COLS)) ? COL_CALC_W'(c_eff)
               : COL_CALC_W'(MAX_COLS - 1);
  assign idx   = idx_w[AW-1:0];

  // window stage math
  logic [ROW_CALC_W-1:0] r_x, r_nx;
  logic [COL_CALC_W-1:0] c_x, c_nx;
  logic interior, last, c_wrap, r_wrap;
  logic signed [DIFF_W-1:0] dr, dc;
  assign r_x  = ROW_CALC_W'(r_q);
  assign c_x  = COL_CALC_W'(c_q);
  assign r_nx = r_x + ROW_CALC_W'(1);
  assign c_nx = c_x + COL_CALC_W'(1);
  assign interior = (r_x >= ROW_CALC_W'(2)) && (r_x <= rows_c - ROW_CALC_W'(1)) &&
                    (c_x >= COL_CALC_W'(2)) && (c_x <= cols_c - COL_CALC_W'(1));
  assign last   = (r_x == rows_c - ROW_CALC_W'(1)) && (c_x == cols_c - COL_CALC_W'(1));
  assign c_wrap = (c_nx >= cols_c);
  assign r_wrap = c_wrap && (r_nx >= rows_c);
  assign dr = DIFF_W'(north_q) - (DIFF_W'(ctr_q) <<< 1) + DIFF_W'(south_q);
  assign dc = DIFF_W'(west_q) - (DIFF_W'(ctr_q) <<< 1) + DIFF_W'(mid_rd_q);

  // residual sum and saturation
  localparam int unsigned SUM_W = PROD_W - 7;
  logic signed [SUM_W-1:0] sum;
  logic signed [31:0]      res_sat;
  assign sum = SUM_W'(px_q >>> 8) + SUM_W'(py_q >>> 8) + SUM_W'(src_s_q);
  assign res_sat = (sum > SUM_W'(VMAX)) ? VMAX : (sum < SUM_W'(VMIN)) ? VMIN : sum[31:0];

  // update and magnitude
  localparam int unsigned UPD_W = STEP_W - 31;
  logic signed [UPD_W-1:0] upd;
  logic signed [31:0]      u_sat;
  logic [MAG_W-1:0]        mag, new_max;
  assign upd = UPD_W'(pt_q >>> 32) + UPD_W'(ctr_s_q);
  assign u_sat = (upd > UPD_W'(VMAX)) ? VMAX : (upd < UPD_W'(VMIN)) ? VMIN : upd[31:0];
  always_comb begin
    if (res_q == VMIN)   mag = {MAG_W{1'b1}};
    else if (res_q < 0)  mag = MAG_W'(-res_q);
    else                 mag = MAG_W'(res_q);
  end
  assign new_max = (mag > max_q) ? mag : max_q;

  // row stores: registered read at accept, write in window stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      up_rd_q  <= upper_mem[idx];
      mid_rd_q <= middle_mem[idx];
      src_rd_q <= source_mem[idx];
    end
    if (cmd_i.window) begin
      upper_mem[idx_q]  <= mid_rd_q;
      middle_mem[idx_q] <= u_in_q;
      source_mem[idx_q] <= s_in_q;
    end
  end

  // item payload and pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      u_in_q <= u_prev_i;
      s_in_q <= source_i;
      idx_q  <= idx;
      r_q    <= r_eff;
      c_q    <= c_eff;
    end
    if (cmd_i.window) begin
      dr_q       <= dr;
      dc_q       <= dc;
      src_s_q    <= wsrc_q;
      ctr_s_q    <= ctr_q;
      last_q     <= last;
      wrap_q     <= r_wrap;
    end
    if (cmd_i.mul) begin
      px_q <= PROD_W'(dr_q) * $signed({1'b0, cfg_i.coef_x});
      py_q <= PROD_W'(dc_q) * $signed({1'b0, cfg_i.coef_y});
    end
    if (cmd_i.sum) res_q <= res_sat;
    if (cmd_i.step) pt_q <= STEP_W'(res_q) * $signed({1'b0, cfg_i.time_step});
  end

  // window registers, positions and running maximum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      west_q     <= '0;
      ctr_q      <= '0;
      north_q    <= '0;
      south_q    <= '0;
      wsrc_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
      max_q      <= '0;
    end else begin
      if (cmd_i.accept && first_i) max_q <= '0;
      if (cmd_i.window) begin
        west_q     <= ctr_q;
        ctr_q      <= mid_rd_q;
        north_q    <= up_rd_q;
        south_q    <= u_in_q;
        wsrc_q     <= src_rd_q;
        col_q      <= c_wrap ? '0 : c_nx[COL_W-1:0];
        row_q      <= r_wrap ? '0 : (c_wrap ? r_nx[ROW_W-1:0] : r_q);
        if (!interior && r_wrap) max_q <= '0;
      end
      if (cmd_i.finish) max_q <= wrap_q ? '0 : new_max;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      u_new_o            <= u_sat;
      node_residual_o    <= res_q;
      row_index_o        <= r_q - ROW_W'(1);
      col_index_o        <= c_q - COL_W'(1);
      max_abs_residual_o <= new_max;
      last_of_sweep_o    <= last_q;
      converged_o        <= last_q && (new_max < cfg_i.converge_limit);
    end
  end

  assign status_o.interior = interior;
  assign status_o.out_free = !out_valid_o || out_ready_i;

endmodule

FILE: design/five_point_stencil_euler_update_unit.sv
// ----------------------------------------------------------------------------
// five_point_stencil_euler_update_unit: streamed 5-point Laplacian Euler step
// Sequencing: an interior node steps through window, multiply, sum, step and
// finish, a boundary node back to idle after window. One node at a time, set
// by the sequenced multiply path and the single-port row stores.
// Reset: async active low; registers go to defaults, positions and running
// maximum clear, row store contents are undefined until written.
// ----------------------------------------------------------------------------
module five_point_stencil_euler_update_unit
  import fse_pkg::*;
#(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input logic        clk_i,
  input logic        rst_ni,
  fse_in_if.sink     in_i,
  fse_out_if.source  out_o,
  fse_cfg_if.sink    cfg_i
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  fse_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  fse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fse_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .status_o           (status),
    .u_prev_i           (in_i.u_prev),
    .source_i           (in_i.source_term),
    .first_i            (in_i.first_of_grid),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .u_new_o            (out_o.u_new),
    .node_residual_o    (out_o.node_residual),
    .row_index_o        (out_o.row_index),
    .col_index_o        (out_o.col_index),
    .max_abs_residual_o (out_o.max_abs_residual),
    .last_of_sweep_o    (out_o.last_of_sweep),
    .converged_o        (out_o.converged)
  );

endmodule

FILE: design/fse_checker.sv
// ----------------------------------------------------------------------------
// fse_checker: port-level checks of the stencil update unit
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module fse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] u_new,
  input logic [11:0] row_index,
  input logic [9:0]  col_index,
  input logic        last_of_sweep,
  input logic        converged
);

  // a result waiting for the sink holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(u_new))
    else $error("stalled result changed");

  // one node at a time: no accept on the cycle after an accept
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back accept");

  // convergence is only reported on the last node
  a_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && converged |-> last_of_sweep)
    else $error("converged without last_of_sweep");

  // results only for interior nodes
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> row_index != 12'd0 && col_index != 10'd0)
    else $error("result on boundary node");

endmodule

bind five_point_stencil_euler_update_unit fse_checker u_fse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (in_i.valid),
  .in_ready      (in_i.ready),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .u_new         (out_o.u_new),
  .row_index     (out_o.row_index),
  .col_index     (out_o.col_index),
  .last_of_sweep (out_o.last_of_sweep),
  .converged     (out_o.converged)
);
